// ===== design/ttm_pkg.sv =====
`default_nettype none
package ttm_pkg;

  // Widths of the stored timer fields
  localparam int TICK_W      = 48;
  localparam int PERIOD_W    = 32;
  localparam int BASE_W      = 10;
  localparam int DIV_W       = 32;
  localparam int MAX_RESULTS = 16;
  localparam int RC_W        = $clog2(MAX_RESULTS + 1);

  // Command codes on the mode field
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_CREATE  = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_RESTART = 3'd3;
  localparam logic [2:0] MODE_REMOVE  = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_BAD_IVL   = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // Result kinds
  localparam logic KIND_RESP   = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // One timer entry as held in the slot memory
  typedef struct packed {
    logic                running;
    logic                periodic;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   expiry;
  } slot_entry_t;

  // Divider status toward the controller
  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [BASE_W-1:0] rem;
  } div_res_t;

  // Base tick length in milliseconds; codes above the list mean 1000ms
  function automatic logic [BASE_W-1:0] base_ms(input logic [2:0] sel);
    logic [BASE_W-1:0] v;
    unique case (sel)
      3'd0:    v = 10'd10;
      3'd1:    v = 10'd100;
      3'd2:    v = 10'd250;
      3'd3:    v = 10'd500;
      default: v = 10'd1000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/ttm_slot_mem.sv =====
`default_nettype none
module ttm_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire ttm_pkg::slot_entry_t wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output ttm_pkg::slot_entry_t      rdata
);

  ttm_pkg::slot_entry_t mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/ttm_div.sv =====
`default_nettype none
module ttm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ttm_pkg::DIV_W-1:0]  dividend,
  input  wire logic [ttm_pkg::BASE_W-1:0] divisor,
  output ttm_pkg::div_res_t               res
);

  localparam int CW = $clog2(ttm_pkg::DIV_W);

  logic                       busy;
  logic                       done;
  logic [CW-1:0]              cnt;
  logic [ttm_pkg::DIV_W-1:0]  q;
  logic [ttm_pkg::BASE_W-1:0] r;
  logic [ttm_pkg::BASE_W:0]   r_sh;
  logic [ttm_pkg::BASE_W:0]   r_sub;
  logic                       ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign r_sh  = {r, q[ttm_pkg::DIV_W-1]};
  assign ge    = r_sh >= {1'b0, divisor};
  assign r_sub = r_sh - {1'b0, divisor};

  // Step counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(ttm_pkg::DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
    end else if (busy) begin
      q <= {q[ttm_pkg::DIV_W-2:0], ge};
      r <= ge ? r_sub[ttm_pkg::BASE_W-1:0] : r_sh[ttm_pkg::BASE_W-1:0];
    end
  end

  assign res.done = done;
  assign res.quot = q;
  assign res.rem  = r;

endmodule
`default_nettype wire

// ===== design/timer_table_manager_core.sv =====
`default_nettype none
// Channel   Dir  Handshake                 Payload
// cfg       in   psel/penable/pwrite/pready base_interval at paddr 0
// in        in   in_valid / in_stall        mode, timer_id, interval_ms, cyclic
// out       out  out_valid / out_stall      kind, status, slot, last
//
// Tick: the scan reads one slot memory entry per cycle while it is not held.
// Create: the 32-step divider and the free-slot search run side by side.
// Stop and restart: read, write back, respond; remove: clear the valid bit, respond.
// Reset clears the tick count, the slot valid bits and the control state;
// the slot memory is not cleared and its contents are only used for valid slots.
// The scan holds on a reporting slot while an earlier event waits and the output register is stalled.
module timer_table_manager_core #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [3:0]  timer_id,
  input  wire logic [31:0] interval_ms,
  input  wire logic        cyclic,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [1:0]       status,
  output logic [3:0]       slot,
  output logic             last
);

  localparam int SW = $clog2(TIMER_SLOTS);

  localparam logic REG_BASE_INTERVAL = 1'b0;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SCAN_END = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_CMD      = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0]                  state;
  logic [2:0]                  base_interval;
  logic [ttm_pkg::TICK_W-1:0]  tick_count;
  logic [TIMER_SLOTS-1:0]      slot_valid;
  logic [2:0]                  mode_q;
  logic                        cyc_q;
  logic                        ivl_zero;
  logic [SW-1:0]               cmd_idx;
  logic [1:0]                  resp_status;
  logic [3:0]                  resp_slot;
  logic [SW-1:0]               scan_idx;
  logic [ttm_pkg::RC_W-1:0]    rep_cnt;
  logic                        pend_valid;
  logic [SW-1:0]               pend_slot;
  logic [SW-1:0]               free_idx;
  logic                        free_done;
  logic                        free_found;

  logic                        in_acc;
  logic                        cfg_wr;
  logic                        id_in_range;
  logic [SW-1:0]               id_idx;
  logic                        id_found;
  logic                        out_free;
  logic                        hit;
  logic                        report;
  logic                        scan_last;
  logic                        scan_hold;
  logic                        create_go;
  logic                        create_ok;
  logic [ttm_pkg::BASE_W-1:0]  div_divisor;
  logic [ttm_pkg::PERIOD_W-1:0] rst_period;

  logic                        push_req;
  logic                        push_kind;
  logic [1:0]                  push_status;
  logic [3:0]                  push_slot;
  logic                        push_last;
  logic                        out_load;

  logic                        mem_we;
  logic [SW-1:0]               mem_waddr;
  ttm_pkg::slot_entry_t        mem_wdata;
  logic                        mem_re;
  logic [SW-1:0]               mem_raddr;
  ttm_pkg::slot_entry_t        mem_rdata;
  ttm_pkg::div_res_t           div_res;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BASE_INTERVAL);
  assign prdata = (paddr[2] == REG_BASE_INTERVAL) ? {29'd0, base_interval} : 32'd0;

  // Input decode
  assign in_stall    = (state != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign id_in_range = {28'd0, timer_id} < 32'(TIMER_SLOTS);
  assign id_idx      = SW'(timer_id);
  assign id_found    = id_in_range && slot_valid[id_idx];
  assign out_free    = !out_valid || !out_stall;
  assign div_divisor = ttm_pkg::base_ms(base_interval);

  // Scan evaluation of the entry held in the slot memory output register
  assign hit       = slot_valid[scan_idx] && mem_rdata.running &&
                     (mem_rdata.expiry == tick_count);
  assign report    = hit && (rep_cnt < ttm_pkg::RC_W'(ttm_pkg::MAX_RESULTS));
  assign scan_last = (scan_idx == SW'(TIMER_SLOTS - 1));
  assign scan_hold = report && pend_valid && !out_free;

  // Create decision once the divider and the free-slot search are done
  assign create_go  = div_res.done && free_done;
  assign create_ok  = create_go && !ivl_zero && (div_res.rem == '0) && free_found;
  assign rst_period = (mem_rdata.period == '0) ? ttm_pkg::PERIOD_W'(1) : mem_rdata.period;

  // Slot memory access
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = id_idx;
    mem_we    = 1'b0;
    mem_waddr = cmd_idx;
    mem_wdata = mem_rdata;
    unique case (state)
      S_IDLE: begin
        mem_re    = in_acc && ((mode == ttm_pkg::MODE_TICK) ||
                    (((mode == ttm_pkg::MODE_STOP) || (mode == ttm_pkg::MODE_RESTART)) &&
                    id_found));
        mem_raddr = (mode == ttm_pkg::MODE_TICK) ? '0 : id_idx;
      end
      S_SCAN: begin
        mem_re    = !scan_hold && !scan_last;
        mem_raddr = scan_idx + 1'b1;
        mem_we    = !scan_hold && hit;
        mem_waddr = scan_idx;
        if (mem_rdata.periodic) begin
          mem_wdata.expiry = tick_count + ttm_pkg::TICK_W'(mem_rdata.period);
        end else begin
          mem_wdata.running = 1'b0;
        end
      end
      S_DIV: begin
        mem_we             = create_ok;
        mem_waddr          = free_idx;
        mem_wdata.running  = 1'b1;
        mem_wdata.periodic = cyc_q;
        mem_wdata.period   = div_res.quot;
        mem_wdata.expiry   = tick_count + ttm_pkg::TICK_W'(div_res.quot);
      end
      S_CMD: begin
        mem_we = 1'b1;
        if (mode_q == ttm_pkg::MODE_STOP) begin
          mem_wdata.running = 1'b0;
        end else begin
          mem_wdata.running = 1'b1;
          mem_wdata.expiry  = tick_count + ttm_pkg::TICK_W'(rst_period);
        end
      end
      default: begin
      end
    endcase
  end

  // Result selection toward the output register
  always_comb begin
    push_req    = 1'b0;
    push_kind   = ttm_pkg::KIND_EXPIRY;
    push_status = ttm_pkg::STAT_OK;
    push_slot   = 4'(pend_slot);
    push_last   = 1'b0;
    unique case (state)
      S_SCAN: begin
        push_req = report && pend_valid;
      end
      S_SCAN_END: begin
        push_req  = pend_valid;
        push_last = 1'b1;
      end
      S_RESP: begin
        push_req    = 1'b1;
        push_kind   = ttm_pkg::KIND_RESP;
        push_status = resp_status;
        push_slot   = resp_slot;
        push_last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_load = push_req && out_free;

  // Sequencer, tick count, valid bits and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      base_interval <= '0;
      tick_count    <= '0;
      slot_valid    <= '0;
      pend_valid    <= 1'b0;
      free_done     <= 1'b0;
      free_found    <= 1'b0;
      scan_idx      <= '0;
      rep_cnt       <= '0;
      free_idx      <= '0;
    end else begin
      if (cfg_wr) begin
        base_interval <= pwdata[2:0];
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (mode)
              ttm_pkg::MODE_TICK: begin
                tick_count <= tick_count + 1'b1;
                scan_idx   <= '0;
                rep_cnt    <= '0;
                pend_valid <= 1'b0;
                state      <= S_SCAN;
              end
              ttm_pkg::MODE_CREATE: begin
                free_idx   <= '0;
                free_done  <= 1'b0;
                free_found <= 1'b0;
                state      <= S_DIV;
              end
              ttm_pkg::MODE_STOP, ttm_pkg::MODE_RESTART, ttm_pkg::MODE_REMOVE: begin
                if (!id_found) begin
                  state <= S_RESP;
                end else if (mode == ttm_pkg::MODE_REMOVE) begin
                  slot_valid[id_idx] <= 1'b0;
                  state              <= S_RESP;
                end else begin
                  state <= S_CMD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!scan_hold) begin
            if (report) begin
              pend_valid <= 1'b1;
              rep_cnt    <= rep_cnt + 1'b1;
            end
            if (scan_last) begin
              state <= S_SCAN_END;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end
        S_SCAN_END: begin
          if (!pend_valid || out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          // Walk the valid bits for the lowest free slot
          if (!free_done) begin
            if (!slot_valid[free_idx]) begin
              free_done  <= 1'b1;
              free_found <= 1'b1;
            end else if (free_idx == SW'(TIMER_SLOTS - 1)) begin
              free_done <= 1'b1;
            end else begin
              free_idx <= free_idx + 1'b1;
            end
          end
          if (create_go) begin
            if (create_ok) begin
              slot_valid[free_idx] <= 1'b1;
            end
            state <= S_RESP;
          end
        end
        S_CMD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command context and response payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_q      <= mode;
      cyc_q       <= cyclic;
      ivl_zero    <= (interval_ms == 32'd0);
      cmd_idx     <= id_idx;
      resp_slot   <= timer_id;
      resp_status <= id_found ? ttm_pkg::STAT_OK : ttm_pkg::STAT_NOT_FOUND;
    end
    if ((state == S_SCAN) && !scan_hold && report) begin
      pend_slot <= scan_idx;
    end
    if ((state == S_DIV) && create_go) begin
      priority if (ivl_zero || (div_res.rem != '0)) begin
        resp_status <= ttm_pkg::STAT_BAD_IVL;
        resp_slot   <= 4'd0;
      end else if (!free_found) begin
        resp_status <= ttm_pkg::STAT_FULL;
        resp_slot   <= 4'd0;
      end else begin
        resp_status <= ttm_pkg::STAT_OK;
        resp_slot   <= 4'(free_idx);
      end
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind   <= push_kind;
      status <= push_status;
      slot   <= push_slot;
      last   <= push_last;
    end
  end

  ttm_slot_mem #(
    .DEPTH (TIMER_SLOTS),
    .AW    (SW)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ttm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc && (mode == ttm_pkg::MODE_CREATE)),
    .dividend (interval_ms),
    .divisor  (div_divisor),
    .res      (div_res)
  );

`ifndef ASSERT_OFF
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    in_acc && (mode == ttm_pkg::MODE_TICK) |=> tick_count == $past(tick_count) + 48'd1)
    else $error("tick count did not advance by one");

  a_resp_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == ttm_pkg::KIND_RESP) |-> last)
    else $error("command response not marked last");

  a_expiry_in_tick: assert property (@(posedge clk) disable iff (rst)
    out_load && (push_kind == ttm_pkg::KIND_EXPIRY) |-> mode_q == ttm_pkg::MODE_TICK)
    else $error("expiry event outside a tick");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && div_res.done |-> div_res.rem < div_divisor)
    else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire
